// ===== design/gdd_pkg.sv =====
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared types, constants and calendar tables for the date difference block.
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned DIFF_W   = 17;
  localparam int unsigned WDAY_W   = 3;
  localparam int unsigned MLEN_W   = 5;

  // shifted year (year + 400) and its predecessor
  localparam int unsigned SYEAR_W  = 13;
  // day number of the first of a month, shifted origin
  localparam int unsigned DNUM_W   = 21;
  localparam int unsigned SUM_W    = DNUM_W + 1;

  localparam logic [SYEAR_W-1:0] YEAR_SHIFT = 13'd400;

  // x / 25 = (x * 1311) >> 15, exact for x below 4681
  localparam int unsigned         DIV25_W     = 11;
  localparam int unsigned         DIV25_PROD_W = 22;
  localparam logic [DIV25_W-1:0]  DIV25_MUL   = 11'd1311;
  localparam int unsigned         DIV25_SHIFT = 15;

  // x / 7 = (x * 2396746) >> 24, exact for x below 2796202
  localparam int unsigned         MOD7_MUL_W  = 22;
  localparam int unsigned         MOD7_PROD_W = DNUM_W + MOD7_MUL_W;
  localparam logic [MOD7_MUL_W-1:0] MOD7_MUL  = 22'd2396746;
  localparam int unsigned         MOD7_SHIFT  = 24;

  localparam logic [DIFF_W-1:0] DIFF_MAX = 17'd131071;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_YEAR_REV  = 2'd1,
    STATUS_MONTH_REV = 2'd2,
    STATUS_DAY_REV   = 2'd3
  } status_e;

  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  function automatic logic [MONTH_W-1:0] fix_month(input logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] r;
    r = m;
    if (m == '0) begin
      r = MONTH_JAN;
    end else if (m > MONTH_DEC) begin
      r = MONTH_DEC;
    end
    return r;
  endfunction

  // days before the first of the month in a common year
  function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      default: r = 9'd334;
    endcase
    return r;
  endfunction

  function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [MLEN_W-1:0] r;
    case (m)
      4'd2:    r = 5'd28;
      4'd4:    r = 5'd30;
      4'd6:    r = 5'd30;
      4'd9:    r = 5'd30;
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// ===== design/gregorian_date_difference.sv =====
// an accepted input beat is registered in stages 1, 2, 3 and 4 and leaves as the result beat
// throughput: one beat per cycle unless m_axis_tready_i stalls; the four stage registers
// each hold a valid bit and a stage moves on whenever the stage after it is empty or moving
// reset: asynchronous, active low; clears the valid bits only, pipeline data
// is left as is
// ----------------------------------------------------------------------------
// gregorian_date_difference
// Days between two Gregorian dates with order status, plus month length and
// first weekday of the later date's month.
// ----------------------------------------------------------------------------
module gregorian_date_difference (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // later_year[11:0], later_month[15:12], later_day[20:16],
  // earlier_year[32:21], earlier_month[36:33], earlier_day[41:37], zero[47:42]
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // day_difference[16:0], status[18:17], first_weekday[21:19],
  // days_in_month[26:22], zero[31:27]
  output logic [31:0] m_axis_tdata_o
);

  logic [gdd_pkg::YEAR_W-1:0]  ly, ey;
  logic [gdd_pkg::MONTH_W-1:0] lm, em;
  logic [gdd_pkg::DAY_W-1:0]   ld, ed;
  gdd_pkg::status_e            st;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  gdd_pkg::stage_en_t en;

  logic [gdd_pkg::MONTH_W-1:0] lm1_q, lm2_q;
  logic [gdd_pkg::DAY_W-1:0]   ld1_q, ld2_q, ed1_q, ed2_q;
  gdd_pkg::status_e            st1_q, st2_q, st3_q, st4_q;

  logic [gdd_pkg::DNUM_W-1:0]  lnum, enum_n;
  logic                        lleap;

  logic [gdd_pkg::SUM_W-1:0]       a, b, d;
  logic [gdd_pkg::DIFF_W-1:0]      diff3_d, diff3_q, diff4_q;
  logic [gdd_pkg::DNUM_W-1:0]      x3_d, x3_q;
  logic [gdd_pkg::MOD7_PROD_W-1:0] wprod3_d, wprod3_q;
  logic [gdd_pkg::MLEN_W-1:0]      mlen3_d, mlen3_q, mlen4_q;
  logic [gdd_pkg::DNUM_W-1:0]      q7, rem7;
  logic [gdd_pkg::WDAY_W-1:0]      wd4_q;

  // stalls ripple back only as far as the first empty stage
  always_comb begin
    en4 = !v4_q || m_axis_tready_i;
    en3 = !v3_q || en4;
    en2 = !v2_q || en3;
    en1 = !v1_q || en2;
    en.s1 = en1;
    en.s2 = en2;
  end

  assign s_axis_tready_o = en1;
  assign m_axis_tvalid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: unpack, clamp months, order check
  always_comb begin
    ly = s_axis_tdata_i[11:0];
    lm = gdd_pkg::fix_month(s_axis_tdata_i[15:12]);
    ld = s_axis_tdata_i[20:16];
    ey = s_axis_tdata_i[32:21];
    em = gdd_pkg::fix_month(s_axis_tdata_i[36:33]);
    ed = s_axis_tdata_i[41:37];
    if (ly < ey) begin
      st = gdd_pkg::STATUS_YEAR_REV;
    end else if (ly == ey && lm < em) begin
      st = gdd_pkg::STATUS_MONTH_REV;
    end else if (ly == ey && lm == em && ld < ed) begin
      st = gdd_pkg::STATUS_DAY_REV;
    end else begin
      st = gdd_pkg::STATUS_OK;
    end
  end

  gdd_day_number u_later (
    .clk_i    (clk_i),
    .en_i     (en),
    .year_i   (ly),
    .month_i  (lm),
    .number_o (lnum),
    .leap_o   (lleap)
  );

  gdd_day_number u_earlier (
    .clk_i    (clk_i),
    .en_i     (en),
    .year_i   (ey),
    .month_i  (em),
    .number_o (enum_n),
    .leap_o   ()
  );

  always_ff @(posedge clk_i) begin
    if (en1) begin
      lm1_q <= lm;
      ld1_q <= ld;
      ed1_q <= ed;
      st1_q <= st;
    end
    if (en2) begin
      lm2_q <= lm1_q;
      ld2_q <= ld1_q;
      ed2_q <= ed1_q;
      st2_q <= st1_q;
    end
  end

  // stage 3: difference with saturation, month length, weekday product
  always_comb begin
    a       = gdd_pkg::SUM_W'(lnum) + gdd_pkg::SUM_W'(ld2_q);
    b       = gdd_pkg::SUM_W'(enum_n) + gdd_pkg::SUM_W'(ed2_q);
    d       = a - b;
    diff3_d = '0;
    if (st2_q == gdd_pkg::STATUS_OK && a > b) begin
      if (d[gdd_pkg::SUM_W-1:gdd_pkg::DIFF_W] != '0) begin
        diff3_d = gdd_pkg::DIFF_MAX;
      end else begin
        diff3_d = d[gdd_pkg::DIFF_W-1:0];
      end
    end
    mlen3_d = gdd_pkg::month_len(lm2_q);
    if (lm2_q == gdd_pkg::MONTH_FEB && lleap) begin
      mlen3_d = 5'd29;
    end
    // shifted day one is a monday, so sunday-based weekday is (n + 1) mod 7
    x3_d     = lnum + 21'd1;
    wprod3_d = gdd_pkg::MOD7_PROD_W'(x3_d) * gdd_pkg::MOD7_PROD_W'(gdd_pkg::MOD7_MUL);
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      diff3_q  <= diff3_d;
      st3_q    <= st2_q;
      mlen3_q  <= mlen3_d;
      x3_q     <= x3_d;
      wprod3_q <= wprod3_d;
    end
  end

  // stage 4: remainder of the divide by 7, output register
  always_comb begin
    q7   = gdd_pkg::DNUM_W'(wprod3_q[gdd_pkg::MOD7_PROD_W-1:gdd_pkg::MOD7_SHIFT]);
    rem7 = x3_q - q7 * 21'd7;
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      diff4_q <= diff3_q;
      st4_q   <= st3_q;
      wd4_q   <= rem7[gdd_pkg::WDAY_W-1:0];
      mlen4_q <= mlen3_q;
    end
  end

  assign m_axis_tdata_o = {5'd0, mlen4_q, wd4_q, st4_q, diff4_q};

endmodule

// ===== design/gdd_day_number.sv =====
// ----------------------------------------------------------------------------
// gdd_day_number
// Two-stage day number of the first of a month, plus the leap-year flag.
// ----------------------------------------------------------------------------
module gdd_day_number (
  input  logic                              clk_i,
  input  gdd_pkg::stage_en_t                en_i,
  input  logic [gdd_pkg::YEAR_W-1:0]        year_i,
  input  logic [gdd_pkg::MONTH_W-1:0]       month_i,   // already clamped to 1..12
  output logic [gdd_pkg::DNUM_W-1:0]        number_o,
  output logic                              leap_o
);

  logic [gdd_pkg::SYEAR_W-1:0]      y;
  logic [gdd_pkg::SYEAR_W-1:0]      p;
  logic [gdd_pkg::DIV25_W-1:0]      q4p;
  logic [gdd_pkg::DIV25_W-1:0]      q4y;

  logic [gdd_pkg::DNUM_W-1:0]       p365_q, p365_d;
  logic [gdd_pkg::DIV25_PROD_W-1:0] prod_p_q, prod_p_d;
  logic [gdd_pkg::DIV25_PROD_W-1:0] prod_y_q, prod_y_d;
  logic [gdd_pkg::DIV25_W-1:0]      q4p_q;
  logic [gdd_pkg::DIV25_W-1:0]      q4y_q;
  logic [1:0]                       ylow_q;
  logic [gdd_pkg::MONTH_W-1:0]      month_q;

  logic [5:0]                       q100p;
  logic [5:0]                       q100y;
  logic [gdd_pkg::DIV25_W-1:0]      back25;
  logic                             leap;
  logic [gdd_pkg::DNUM_W-1:0]       number_d;
  logic [gdd_pkg::DNUM_W-1:0]       number_q;
  logic                             leap_q;

  // stage 1: shifted year, 365 * p and the divide-by-25 products
  always_comb begin
    y        = {1'b0, year_i} + gdd_pkg::YEAR_SHIFT;
    p        = y - 13'd1;
    q4p      = p[gdd_pkg::SYEAR_W-1:2];
    q4y      = y[gdd_pkg::SYEAR_W-1:2];
    p365_d   = gdd_pkg::DNUM_W'(p) * 21'd365;
    prod_p_d = gdd_pkg::DIV25_PROD_W'(q4p) * gdd_pkg::DIV25_PROD_W'(gdd_pkg::DIV25_MUL);
    prod_y_d = gdd_pkg::DIV25_PROD_W'(q4y) * gdd_pkg::DIV25_PROD_W'(gdd_pkg::DIV25_MUL);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      p365_q   <= p365_d;
      prod_p_q <= prod_p_d;
      prod_y_q <= prod_y_d;
      q4p_q    <= q4p;
      q4y_q    <= q4y;
      ylow_q   <= y[1:0];
      month_q  <= month_i;
    end
  end

  // stage 2: centuries, leap flag and the final sum
  always_comb begin
    q100p  = prod_p_q[gdd_pkg::DIV25_SHIFT +: 6];
    q100y  = prod_y_q[gdd_pkg::DIV25_SHIFT +: 6];
    back25 = gdd_pkg::DIV25_W'(q100y) * 11'd25;
    leap   = (ylow_q == 2'd0) && ((back25 != q4y_q) || (q100y[1:0] == 2'd0));
    number_d = p365_q
             + gdd_pkg::DNUM_W'(q4p_q)
             - gdd_pkg::DNUM_W'(q100p)
             + gdd_pkg::DNUM_W'(q100p[5:2])
             + gdd_pkg::DNUM_W'(gdd_pkg::month_start(month_q))
             + gdd_pkg::DNUM_W'((month_q > gdd_pkg::MONTH_FEB) && leap);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      number_q <= number_d;
      leap_q   <= leap;
    end
  end

  assign number_o = number_q;
  assign leap_o   = leap_q;

endmodule

// ===== design/gdd_checker.sv =====
// ----------------------------------------------------------------------------
// gdd_checker
// Port-level checks on the date difference block, bound to its top level.
// ----------------------------------------------------------------------------
module gdd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  // held output beat keeps its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat dropped or changed while stalled");

  // a reversed order never carries a day count
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[18:17] != gdd_pkg::STATUS_OK)
      |-> m_axis_tdata_o[16:0] == '0)
    else $error("nonzero difference with reversed status");

  // weekday and month length stay in their ranges, spare bits stay zero
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[21:19] <= 3'd6) && (m_axis_tdata_o[26:22] >= 5'd28)
      && (m_axis_tdata_o[26:22] <= 5'd31) && (m_axis_tdata_o[31:27] == '0))
    else $error("weekday or month length out of range");

  // an output after an empty cycle is an input beat that passed with no stall
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 4))
    else $error("output appeared without a matching input beat");

endmodule

bind gregorian_date_difference gdd_checker u_gdd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
